// ----- design/sparse_global_sum_avg_pool_defines.svh -----
// Assertion macros used by the checker of the sparse global pooling block.
// No dependencies; include once through the guard below.
`ifndef SPARSE_GLOBAL_SUM_AVG_POOL_DEFINES_SVH
`define SPARSE_GLOBAL_SUM_AVG_POOL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SGSAP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SGSAP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sgsap_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register indexes and controller/datapath interface structs
// for the sparse global pooling block. No dependencies.
package sgsap_pkg;

    localparam int DATA_W            = 32;
    localparam int SUM_W             = 44;
    localparam int PLANE_IDX_W       = 6;
    localparam int PLANE_CNT_W       = 7;
    localparam int PLANE_COUNT_RESET = 64;

    localparam int MAX_PLANES_DEF    = 64;
    localparam int MAX_SITES_DEF     = 4096;

    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 32;

    // Input tuser bits
    localparam int S_USER_W           = 3;
    localparam int S_USER_LAST_PLANE  = 0;
    localparam int S_USER_EMPTY       = 1;
    localparam int S_USER_LAST_SAMPLE = 2;

    // Output tuser: plane index, then batch end
    localparam int M_USER_W = PLANE_IDX_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE = CFG_IDX_W'(1);

    typedef struct packed {
        logic                   acc_en;
        logic                   rd_en;
        logic                   div_start;
        logic                   out_load;
        logic                   clear;
        logic                   out_zero;
        logic                   out_div;
        logic                   out_final;
        logic                   out_bend;
        logic [PLANE_IDX_W-1:0] out_index;
    } sgsap_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
    } sgsap_stat_t;

endpackage

// ----- design/sgsap_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider: signed accumulator by unsigned site count,
// quotient truncated toward zero. Depends on sgsap_pkg.
module sgsap_div #(
    parameter int DIVISOR_W = 13
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [sgsap_pkg::SUM_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]               divisor,
    output logic                               done,
    output logic signed [sgsap_pkg::SUM_W-1:0] quotient
);
    import sgsap_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W:0] rem_sh;
    logic [DIVISOR_W:0] rem_sub;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, quo_reg[SUM_W-1]};
        rem_sub   = rem_sh - {1'b0, divisor};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next = rem_sub[DIVISOR_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIVISOR_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);

endmodule

// ----- design/sgsap_dp.sv -----
`timescale 1ns / 1ps
// Datapath: per-plane accumulator memory with valid bits, saturating
// accumulate stage, divider and output register. Depends on sgsap_pkg, sgsap_div.
module sgsap_dp #(
    parameter int MAX_PLANES = sgsap_pkg::MAX_PLANES_DEF,
    parameter int MAX_SITES  = sgsap_pkg::MAX_SITES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sgsap_pkg::sgsap_cmd_t                cmd,
    output sgsap_pkg::sgsap_stat_t               stat,
    input  logic [((MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1)-1:0] addr,
    input  logic signed [sgsap_pkg::DATA_W-1:0]  value,
    input  logic [$clog2(MAX_SITES + 1)-1:0]     site_count,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [sgsap_pkg::DATA_W-1:0]  m_tdata,
    output logic                                 m_tlast,
    output logic [sgsap_pkg::M_USER_W-1:0]       m_tuser
);
    import sgsap_pkg::*;

    localparam int PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int SCW = $clog2(MAX_SITES + 1);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                  input logic [DATA_W-1:0] val);
        logic [SUM_W:0] s;
        s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - DATA_W){val[DATA_W-1]}}, val};
        if (s[SUM_W] != s[SUM_W-1])
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            sat_add = s[SUM_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] sat32(input logic [SUM_W-1:0] v);
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            sat32 = v[DATA_W-1:0];
        else
            sat32 = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    logic [SUM_W-1:0]      mem [MAX_PLANES];
    logic [SUM_W-1:0]      mem_q_reg;
    logic [SUM_W-1:0]      byp_data_reg;
    logic                  byp_reg;
    logic                  vld_q_reg;
    logic [MAX_PLANES-1:0] vld_reg, vld_next;

    logic                  wb_pend_reg;
    logic [PW-1:0]         wb_addr_reg;
    logic [DATA_W-1:0]     wb_value_reg;

    logic                  rd_en;
    logic [SUM_W-1:0]      rd_data;
    logic [SUM_W-1:0]      wr_data;
    logic                  div_done;
    logic signed [SUM_W-1:0] quotient;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]     out_data_reg;
    logic [PLANE_IDX_W-1:0] out_idx_reg;
    logic                  out_final_reg;
    logic                  out_bend_reg;
    logic                  out_free;
    logic [DATA_W-1:0]     pooled;

    assign rd_en   = cmd.acc_en | cmd.rd_en;
    assign rd_data = byp_reg ? byp_data_reg : (vld_q_reg ? mem_q_reg : '0);
    assign wr_data = sat_add(rd_data, wb_value_reg);

    // Accumulator memory; a read of the entry being written takes the new sum.
    always_ff @(posedge aclk) begin
        if (wb_pend_reg)
            mem[wb_addr_reg] <= wr_data;
        if (rd_en) begin
            mem_q_reg    <= mem[addr];
            byp_data_reg <= wr_data;
        end
        if (cmd.acc_en) begin
            wb_addr_reg  <= addr;
            wb_value_reg <= value;
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (wb_pend_reg)
            vld_next[wb_addr_reg] = 1'b1;
        if (cmd.clear)
            vld_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            wb_pend_reg <= 1'b0;
            byp_reg     <= 1'b0;
            vld_q_reg   <= 1'b0;
        end else begin
            vld_reg     <= vld_next;
            wb_pend_reg <= cmd.acc_en;
            if (rd_en) begin
                byp_reg   <= wb_pend_reg && (wb_addr_reg == addr);
                vld_q_reg <= vld_reg[addr];
            end
        end
    end

    sgsap_div #(
        .DIVISOR_W(SCW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rd_data),
        .divisor  (site_count),
        .done     (div_done),
        .quotient (quotient)
    );

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;
    assign pooled   = cmd.out_zero ? '0 : sat32(cmd.out_div ? SUM_W'(quotient) : rd_data);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg  <= pooled;
            out_idx_reg   <= cmd.out_index;
            out_final_reg <= cmd.out_final;
            out_bend_reg  <= cmd.out_bend;
        end
    end

    assign stat.out_free = out_free;
    assign stat.div_done = div_done;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_final_reg;
    assign m_tuser  = {out_bend_reg, out_idx_reg};

endmodule

// ----- design/sgsap_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: configuration registers, plane position, site count and the
// state machine that sequences accumulate and emit. Depends on sgsap_pkg.
module sgsap_ctrl #(
    parameter int MAX_PLANES = sgsap_pkg::MAX_PLANES_DEF,
    parameter int MAX_SITES  = sgsap_pkg::MAX_SITES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sgsap_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgsap_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tlast,
    input  logic [sgsap_pkg::S_USER_W-1:0]       s_tuser,
    input  sgsap_pkg::sgsap_stat_t               stat,
    output sgsap_pkg::sgsap_cmd_t                cmd,
    output logic [((MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1)-1:0] addr,
    output logic [$clog2(MAX_SITES + 1)-1:0]     site_count
);
    import sgsap_pkg::*;

    localparam int PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PCW = $clog2(MAX_PLANES + 1);
    localparam int SCW = $clog2(MAX_SITES + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_CALC = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [PLANE_CNT_W-1:0] plane_count_reg, plane_count_next;
    logic                   avg_mode_reg, avg_mode_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [SCW-1:0]         site_cnt_reg, site_cnt_next;
    logic [PW-1:0]          idx_reg, idx_next;
    logic                   empty_reg, empty_next;
    logic                   bend_reg, bend_next;

    logic [PCW-1:0]         planes;
    logic [PCW-1:0]         pos_inc;
    logic                   accept;
    logic                   site_end;
    logic                   last_idx;
    logic                   use_div;

    // Planes in use: zero acts as one, anything above the memory depth clamps.
    always_comb begin
        if (plane_count_reg == '0)
            planes = PCW'(1);
        else if (plane_count_reg > PLANE_CNT_W'(MAX_PLANES))
            planes = PCW'(MAX_PLANES);
        else
            planes = PCW'(plane_count_reg);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign pos_inc   = PCW'(pos_reg) + PCW'(1);
    assign site_end  = s_tuser[S_USER_LAST_PLANE] || s_tlast || (pos_inc >= planes);
    assign last_idx  = ((PCW'(idx_reg) + PCW'(1)) == planes);
    assign use_div   = avg_mode_reg && !empty_reg && (site_cnt_reg != '0);

    always_comb begin
        plane_count_next = plane_count_reg;
        avg_mode_next    = avg_mode_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PLANE_COUNT:  plane_count_next = cfg_data[PLANE_CNT_W-1:0];
                REG_AVERAGE_MODE: avg_mode_next    = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        site_cnt_next = site_cnt_reg;
        idx_next      = idx_reg;
        empty_next    = empty_reg;
        bend_next     = bend_reg;

        cmd           = '0;
        cmd.out_zero  = empty_reg;
        cmd.out_div   = use_div;
        cmd.out_final = last_idx;
        cmd.out_bend  = bend_reg;
        cmd.out_index = PLANE_IDX_W'(idx_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_tuser[S_USER_EMPTY]) begin
                        cmd.acc_en = 1'b1;
                        if (site_end) begin
                            pos_next = '0;
                            if (site_cnt_reg < SCW'(MAX_SITES))
                                site_cnt_next = site_cnt_reg + 1'b1;
                        end else begin
                            pos_next = pos_inc[PW-1:0];
                        end
                    end
                    if (s_tuser[S_USER_EMPTY] || s_tlast) begin
                        idx_next   = '0;
                        empty_next = s_tuser[S_USER_EMPTY];
                        bend_next  = s_tuser[S_USER_LAST_SAMPLE];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (use_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (stat.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (last_idx) begin
                        cmd.clear     = 1'b1;
                        pos_next      = '0;
                        site_cnt_next = '0;
                        state_next    = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            plane_count_reg <= PLANE_CNT_W'(PLANE_COUNT_RESET);
            avg_mode_reg    <= 1'b0;
            pos_reg         <= '0;
            site_cnt_reg    <= '0;
            idx_reg         <= '0;
            empty_reg       <= 1'b0;
            bend_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            plane_count_reg <= plane_count_next;
            avg_mode_reg    <= avg_mode_next;
            pos_reg         <= pos_next;
            site_cnt_reg    <= site_cnt_next;
            idx_reg         <= idx_next;
            empty_reg       <= empty_next;
            bend_reg        <= bend_next;
        end
    end

    assign addr       = (state_reg == ST_IDLE) ? pos_reg : idx_reg;
    assign site_count = site_cnt_reg;

endmodule

// ----- design/sparse_global_sum_avg_pool.sv -----
`timescale 1ns / 1ps
// Sparse global sum / average pooling, top level.
// Depends on sgsap_pkg, sgsap_ctrl, sgsap_dp (and sgsap_div below it).
//
// Use:
//   s_* stream: one plane element of an active site per beat. tdata is the
//   signed Q16.16 element, tlast marks the sample's last site, tuser carries
//   last_plane, empty_sample and last_sample. Elements are added into the
//   accumulator of their plane at one beat per cycle.
//   A beat with tlast or empty_sample ends the sample: input is held off while
//   the block emits one m_* beat per plane (tdata pooled value, tlast on the
//   last plane, tuser plane index and batch end), then clears all sums.
//   cfg_* port: index 0 plane count, index 1 average mode; write while idle.
// Flow:
//   accumulate: the accumulator memory is read as an element is taken and
//   written with the new sum in the cycle after, with write-through on the read side.
//   emit: per plane, READ reads the sum, CALC starts the 44-step bit-serial
//   divider when averaging a non-empty sample, DIV waits, OUT loads the result.
// Reset: synchronous, active low; sums read as zero through per-plane valid
//   bits, so no clearing pass is needed; plane count 64, sum mode.
// Stall: a result waits in the output register; emission holds until taken.
module sparse_global_sum_avg_pool #(
    parameter int MAX_PLANES = sgsap_pkg::MAX_PLANES_DEF,
    parameter int MAX_SITES  = sgsap_pkg::MAX_SITES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sgsap_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgsap_pkg::CFG_DATA_W-1:0]     cfg_data,
    // element stream in
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic signed [sgsap_pkg::DATA_W-1:0]  s_tdata,  // [31:0] value
    input  logic                                 s_tlast,  // last_site
    input  logic [sgsap_pkg::S_USER_W-1:0]       s_tuser,  // [0] last_plane,
                                                           // [1] empty_sample,
                                                           // [2] last_sample
    // pooled result stream out
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [sgsap_pkg::DATA_W-1:0]  m_tdata,  // [31:0] pooled_value
    output logic                                 m_tlast,  // final_plane
    output logic [sgsap_pkg::M_USER_W-1:0]       m_tuser   // [5:0] plane_index,
                                                           // [6] batch_end
);
    import sgsap_pkg::*;

    localparam int PW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int SCW = $clog2(MAX_SITES + 1);

    sgsap_cmd_t      cmd;
    sgsap_stat_t     stat;
    logic [PW-1:0]   addr;
    logic [SCW-1:0]  site_count;

    // Sequence accumulate and emit; hold config, plane position and site count.
    sgsap_ctrl #(
        .MAX_PLANES(MAX_PLANES),
        .MAX_SITES (MAX_SITES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .stat       (stat),
        .cmd        (cmd),
        .addr       (addr),
        .site_count (site_count)
    );

    // Accumulate, divide, saturate and drive the result beat.
    sgsap_dp #(
        .MAX_PLANES(MAX_PLANES),
        .MAX_SITES (MAX_SITES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .addr       (addr),
        .value      (s_tdata),
        .site_count (site_count),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- design/sgsap_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the sparse global pooling block, bound to the top.
// Depends on sgsap_pkg and sparse_global_sum_avg_pool_defines.svh.
`include "sparse_global_sum_avg_pool_defines.svh"

module sgsap_chk (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 s_tlast,
    input logic [sgsap_pkg::S_USER_W-1:0]       s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic signed [sgsap_pkg::DATA_W-1:0]  m_tdata,
    input logic                                 m_tlast,
    input logic [sgsap_pkg::M_USER_W-1:0]       m_tuser
);
    import sgsap_pkg::*;

    logic [PLANE_IDX_W-1:0] exp_idx_reg, exp_idx_next;

    // Track the plane index the next result beat should carry.
    always_comb begin
        exp_idx_next = exp_idx_reg;
        if (m_tvalid && m_tready)
            exp_idx_next = m_tlast ? '0 : m_tuser[PLANE_IDX_W-1:0] + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            exp_idx_reg <= '0;
        else
            exp_idx_reg <= exp_idx_next;
    end

    `SGSAP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")
    `SGSAP_ASSERT_NOW(a_plane_order, aclk, aresetn, m_tvalid && m_tready, m_tuser[PLANE_IDX_W-1:0] == exp_idx_reg, "plane index out of sequence")
    `SGSAP_ASSERT_NEXT(a_end_blocks_in, aclk, aresetn, s_tvalid && s_tready && (s_tlast || s_tuser[S_USER_EMPTY]), !s_tready, "input taken right after sample end")
    `SGSAP_ASSERT_NOW(a_emit_blocks_in, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !s_tready, "input open during emit")

endmodule

bind sparse_global_sum_avg_pool sgsap_chk u_sgsap_chk (.*);
